// ===== rtl/crik_pkg.sv =====
// ----------------------------------------------------------------------------
// crik_pkg: shared types and constants for the cable robot kinematics block
// Field widths, register indexes, the job record passed from front to back,
// and the sizing of the square-root pipeline.
// ----------------------------------------------------------------------------
package crik_pkg;

  localparam int COORD_BITS  = 16;
  localparam int LENGTH_BITS = 16;

  localparam int EXT_W     = 15;
  localparam int MARGIN_W  = 14;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  localparam int BOX_RESET    = 1000;
  localparam int MARGIN_RESET = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_WIDTH  = 3'd0,
    REG_BOX_DEPTH  = 3'd1,
    REG_BOX_HEIGHT = 3'd2,
    REG_MARGIN_X   = 3'd3,
    REG_MARGIN_Y   = 3'd4,
    REG_MARGIN_Z   = 3'd5
  } reg_idx_e;

  // Signed compare width: wide enough for a coordinate and for extent - margin.
  localparam int CMP_W = ((COORD_BITS > EXT_W + 1) ? COORD_BITS : EXT_W + 1) + 1;

  // An in-bounds difference never exceeds an extent.
  localparam int DIFF_W = EXT_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RND_W  = ROOT_W + 1;
  localparam int SAT_W  = (RND_W > LENGTH_BITS) ? RND_W : LENGTH_BITS;

  localparam int STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;

  localparam int NUM_CABLES = 4;
  localparam int CABLE_W    = 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOB = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int IN_DATA_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CABLE_W + LENGTH_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic              oob;
    logic [DIFF_W-1:0] dx0;
    logic [DIFF_W-1:0] dx1;
    logic [DIFF_W-1:0] dy0;
    logic [DIFF_W-1:0] dy1;
    logic [DIFF_W-1:0] dz;
  } job_t;

endpackage

// ===== rtl/crik_front.sv =====
// ----------------------------------------------------------------------------
// crik_front: configuration registers and target classification
// Holds the box geometry, checks a target against the shrunken box and
// produces the axis differences that the back end squares.
// ----------------------------------------------------------------------------
module crik_front
  import crik_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  input  logic signed [COORD_BITS-1:0] target_x_i,
  input  logic signed [COORD_BITS-1:0] target_y_i,
  input  logic signed [COORD_BITS-1:0] target_z_i,
  output job_t                         job_o
);

  logic [EXT_W-1:0]    width_q, depth_q, height_q;
  logic [MARGIN_W-1:0] margin_x_q, margin_y_q, margin_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= EXT_W'(BOX_RESET);
      depth_q    <= EXT_W'(BOX_RESET);
      height_q   <= EXT_W'(BOX_RESET);
      margin_x_q <= MARGIN_W'(MARGIN_RESET);
      margin_y_q <= MARGIN_W'(MARGIN_RESET);
      margin_z_q <= MARGIN_W'(MARGIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_WIDTH:  width_q    <= cfg_data_i[EXT_W-1:0];
        REG_BOX_DEPTH:  depth_q    <= cfg_data_i[EXT_W-1:0];
        REG_BOX_HEIGHT: height_q   <= cfg_data_i[EXT_W-1:0];
        REG_MARGIN_X:   margin_x_q <= cfg_data_i[MARGIN_W-1:0];
        REG_MARGIN_Y:   margin_y_q <= cfg_data_i[MARGIN_W-1:0];
        REG_MARGIN_Z:   margin_z_q <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CMP_W-1:0] x_s, y_s, z_s, w_s, d_s, h_s, mx_s, my_s, mz_s;
  logic signed [CMP_W-1:0] rx_s, ry_s, rz_s;
  logic                    in_x, in_y, in_z;

  assign x_s  = CMP_W'(target_x_i);
  assign y_s  = CMP_W'(target_y_i);
  assign z_s  = CMP_W'(target_z_i);
  assign w_s  = signed'(CMP_W'(width_q));
  assign d_s  = signed'(CMP_W'(depth_q));
  assign h_s  = signed'(CMP_W'(height_q));
  assign mx_s = signed'(CMP_W'(margin_x_q));
  assign my_s = signed'(CMP_W'(margin_y_q));
  assign mz_s = signed'(CMP_W'(margin_z_q));

  // Both bounds are inclusive; a margin over half the extent empties the box.
  assign in_x = (x_s >= mx_s) && (x_s <= w_s - mx_s);
  assign in_y = (y_s >= my_s) && (y_s <= d_s - my_s);
  assign in_z = (z_s >= mz_s) && (z_s <= h_s - mz_s);

  assign rx_s = w_s - x_s;
  assign ry_s = d_s - y_s;
  assign rz_s = h_s - z_s;

  always_comb begin
    job_o.oob = !(in_x && in_y && in_z);
    job_o.dx0 = x_s[DIFF_W-1:0];
    job_o.dx1 = rx_s[DIFF_W-1:0];
    job_o.dy0 = y_s[DIFF_W-1:0];
    job_o.dy1 = ry_s[DIFF_W-1:0];
    job_o.dz  = rz_s[DIFF_W-1:0];
  end

endmodule

// ===== rtl/crik_queue.sv =====
// ----------------------------------------------------------------------------
// crik_queue: short job queue between front and back end
// A small first-in first-out store of classified targets.
// ----------------------------------------------------------------------------
module crik_queue
  import crik_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic valid_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/crik_back.sv =====
// ----------------------------------------------------------------------------
// crik_back: per-cable length pipeline
// Issues one cable per cycle from the queue head while the output is not
// stalled, squares and sums the axis differences, takes a rounded integer square
// root two bits per stage and holds the result in the output register.
// ----------------------------------------------------------------------------
module crik_back
  import crik_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  job_t                  job_i,
  input  logic                  job_valid_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic                  status_o,
  output logic [CABLE_W-1:0]    cable_index_o,
  output logic [LENGTH_BITS-1:0] cable_mm_o,
  output logic                  last_o
);

  typedef struct packed {
    logic               oob;
    logic [CABLE_W-1:0] idx;
    logic               last;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  sv;
  } sq_t;

  function automatic sq_t sq_step(sq_t a);
    sq_t              b;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {a.rem[REM_W-3:0], a.sv[SUM_W-1 -: 2]};
    trial  = {a.root, 2'b01};
    if (rem_sh >= trial) begin
      b.rem  = rem_sh - trial;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = rem_sh;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    b.sv = {a.sv[SUM_W-3:0], 2'b00};
    return b;
  endfunction

  // One pipeline stage worth of root digits.
  function automatic sq_t sq_stage(sq_t a);
    sq_t b;
    b = a;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      b = sq_step(b);
    end
    return b;
  endfunction

  localparam logic [CABLE_W-1:0] CABLE_LAST = CABLE_W'(NUM_CABLES - 1);

  logic adv;
  logic issue;
  logic [CABLE_W-1:0] cnt_q;

  assign adv   = !m_tvalid_o || m_tready_i;
  assign issue = job_valid_i && adv;
  assign pop_o = issue && (job_i.oob || cnt_q == CABLE_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (issue) begin
      if (job_i.oob || cnt_q == CABLE_LAST) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Square stage.
  logic [DIFF_W-1:0] dx, dy;
  tag_t              iss_tag;
  logic              va_q;
  tag_t              ta_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;

  assign dx = cnt_q[0] ? job_i.dx1 : job_i.dx0;
  assign dy = cnt_q[1] ? job_i.dy1 : job_i.dy0;

  always_comb begin
    iss_tag.oob  = job_i.oob;
    iss_tag.idx  = job_i.oob ? '0 : cnt_q;
    iss_tag.last = job_i.oob || (cnt_q == CABLE_LAST);
  end

  // Sum stage.
  logic             vb_q;
  tag_t             tb_q;
  logic [SUM_W-1:0] sum_q;

  // Root stages.
  logic vs_q [SQRT_STAGES];
  tag_t ts_q [SQRT_STAGES];
  sq_t  ss_q [SQRT_STAGES];
  sq_t  ss_d [SQRT_STAGES];
  sq_t  sq_first;

  always_comb begin
    sq_first.rem  = '0;
    sq_first.root = '0;
    sq_first.sv   = sum_q;
    ss_d[0] = sq_stage(sq_first);
    for (int s = 1; s < SQRT_STAGES; s++) begin
      ss_d[s] = sq_stage(ss_q[s-1]);
    end
  end

  // Rounding and saturation.
  sq_t              fin;
  logic [RND_W-1:0] rounded;
  logic [SAT_W-1:0] ext, lmax, sat;

  assign fin     = ss_q[SQRT_STAGES-1];
  assign rounded = RND_W'(fin.root) + RND_W'(fin.rem > REM_W'(fin.root));
  assign ext     = SAT_W'(rounded);
  assign lmax    = SAT_W'({LENGTH_BITS{1'b1}});
  assign sat     = (ext > lmax) ? lmax : ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q       <= 1'b0;
      vb_q       <= 1'b0;
      m_tvalid_o <= 1'b0;
      for (int s = 0; s < SQRT_STAGES; s++) begin
        vs_q[s] <= 1'b0;
      end
    end else if (adv) begin
      va_q    <= issue;
      vb_q    <= va_q;
      vs_q[0] <= vb_q;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        vs_q[s] <= vs_q[s-1];
      end
      m_tvalid_o <= vs_q[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ta_q    <= iss_tag;
      sqx_q   <= SQ_W'(dx) * SQ_W'(dx);
      sqy_q   <= SQ_W'(dy) * SQ_W'(dy);
      sqz_q   <= SQ_W'(job_i.dz) * SQ_W'(job_i.dz);
      tb_q    <= ta_q;
      sum_q   <= SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
      ts_q[0] <= tb_q;
      for (int s = 1; s < SQRT_STAGES; s++) begin
        ts_q[s] <= ts_q[s-1];
      end
      for (int s = 0; s < SQRT_STAGES; s++) begin
        ss_q[s] <= ss_d[s];
      end
      status_o      <= ts_q[SQRT_STAGES-1].oob ? STATUS_OOB : STATUS_OK;
      cable_index_o <= ts_q[SQRT_STAGES-1].idx;
      last_o        <= ts_q[SQRT_STAGES-1].last;
      cable_mm_o    <= ts_q[SQRT_STAGES-1].oob ? '0 : sat[LENGTH_BITS-1:0];
    end
  end

endmodule

// ===== rtl/cable_robot_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// cable_robot_inverse_kinematics: cable lengths for a four-cable payload robot
// Usage notes follow. A target point enters on the slave stream; one beat
// carries x, y and z. The front end checks the point against the box shrunk
// by the per-axis margins and queues it. A point outside gives one result
// beat with status set and length zero. A point inside gives four beats, one
// per cable (front-left, front-right, rear-left, rear-right), each with the
// length to that anchor rounded to the nearest millimetre; tlast marks the
// final beat of a target.
// Throughput: the back end issues one cable per cycle while the result stream
// is not stalled, so the one result stream limits the rate. A target beat passes
// through the queue register, then issue and square, sum, eight square-root
// stages of two bits each, and the output register.
// Reset loads the default 1000 mm cube with zero margins and empties the queue
// and pipeline. When the receiver stalls, the whole back-end pipeline holds; the
// four-entry queue keeps taking targets until it fills. The user must see that
// configuration registers are written while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cable_robot_inverse_kinematics
  import crik_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // Target stream.
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // target_x, target_y, target_z
  // Result stream.
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,   // cable_index, cable_mm, zero pad
  output logic [0:0]            m_tuser_o,   // status
  output logic                  m_tlast_o
);

  job_t front_job;
  job_t head_job;
  logic q_full, q_valid, q_pop;

  logic                   status;
  logic [CABLE_W-1:0]     cable_index;
  logic [LENGTH_BITS-1:0] cable_mm;

  // The front end classifies combinationally; the queue registers the result.
  crik_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .target_x_i (signed'(s_tdata_i[COORD_BITS-1:0])),
    .target_y_i (signed'(s_tdata_i[2*COORD_BITS-1:COORD_BITS])),
    .target_z_i (signed'(s_tdata_i[3*COORD_BITS-1:2*COORD_BITS])),
    .job_o      (front_job)
  );

  assign s_tready_o = !q_full;

  crik_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_tvalid_i),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (head_job),
    .valid_o (q_valid)
  );

  crik_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_valid_i   (q_valid),
    .pop_o         (q_pop),
    .m_tvalid_o    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .status_o      (status),
    .cable_index_o (cable_index),
    .cable_mm_o    (cable_mm),
    .last_o        (m_tlast_o)
  );

  // Result beat packing: cable index in the low bits, then the length.
  assign m_tdata_o = OUT_DATA_W'({cable_mm, cable_index});
  assign m_tuser_o = status;

endmodule
